FILE: rtl/core/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

    // Header and trailer bytes of a frame.
    localparam logic [7:0] HDR_A = 8'hAA;
    localparam logic [7:0] HDR_B = 8'h55;
    localparam logic [7:0] TRL_A = 8'h0D;
    localparam logic [7:0] TRL_B = 8'h0A;

    // Frame geometry: bytes 2..16 are payload and are covered by the sum.
    localparam int FRAME_LEN = 20;
    localparam int SUM_SPAN  = 15;
    localparam int PAY_W     = SUM_SPAN * 8;
    localparam int POS_W     = 5;

    // Parser positions.
    localparam logic [POS_W-1:0] POS_HUNT  = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR   = 5'd1;
    localparam logic [POS_W-1:0] POS_DATA  = 5'd2;
    localparam logic [POS_W-1:0] POS_LAST  = 5'(2 + SUM_SPAN - 1);
    localparam logic [POS_W-1:0] POS_CHK   = 5'(2 + SUM_SPAN);
    localparam logic [POS_W-1:0] POS_TRL_A = 5'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_TRL_B = 5'(FRAME_LEN - 1);

    // Default depth of the queue between parser and output stage.
    localparam int QUEUE_DEPTH_DEF = 2;

    // One parsed frame, with its validation verdict.
    typedef struct packed {
        logic [7:0]  action_code;
        logic [15:0] roll_raw;
        logic [31:0] z_raw;
        logic [31:0] y_raw;
        logic [31:0] x_raw;
        logic        ok;
    } t_frame;

endpackage

`default_nettype wire

FILE: rtl/core/sfd_front.sv
`default_nettype none

module sfd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_rx_byte,
    output logic                o_ready,
    input  wire logic           i_full,
    output logic                o_push,
    output sfd_pkg::t_frame     o_frame
);

    logic [sfd_pkg::POS_W-1:0] r_pos;
    logic [sfd_pkg::POS_W-1:0] n_pos;
    logic [sfd_pkg::PAY_W-1:0] r_pay;
    logic [7:0]                r_sum;
    logic [7:0]                r_chk;
    logic                      r_trl_ok;
    logic                      w_take;

    // Only the last byte of a frame needs room in the queue.
    assign o_ready = (r_pos != sfd_pkg::POS_TRL_B) || !i_full;
    assign w_take  = i_valid && o_ready;
    assign o_push  = w_take && (r_pos == sfd_pkg::POS_TRL_B);

    // Next parser position.
    always_comb begin
        n_pos = r_pos;
        case (r_pos)
            sfd_pkg::POS_HUNT: begin
                if (i_rx_byte == sfd_pkg::HDR_A) n_pos = sfd_pkg::POS_HDR;
            end
            sfd_pkg::POS_HDR: begin
                if (i_rx_byte == sfd_pkg::HDR_B) begin
                    n_pos = sfd_pkg::POS_DATA;
                end else if (i_rx_byte == sfd_pkg::HDR_A) begin
                    n_pos = sfd_pkg::POS_HDR;
                end else begin
                    n_pos = sfd_pkg::POS_HUNT;
                end
            end
            sfd_pkg::POS_TRL_B: n_pos = sfd_pkg::POS_HUNT;
            default: begin
                if (r_pos > sfd_pkg::POS_TRL_B) begin
                    n_pos = sfd_pkg::POS_HUNT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
        endcase
    end

    // Position register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= sfd_pkg::POS_HUNT;
        end else if (w_take) begin
            r_pos <= n_pos;
        end
    end

    // Payload shift line, running sum, checksum byte and first trailer check.
    // After the last payload byte, byte 2 sits in the lowest lane.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_pos == sfd_pkg::POS_HDR) begin
                r_sum <= '0;
            end
            if (r_pos >= sfd_pkg::POS_DATA && r_pos <= sfd_pkg::POS_LAST) begin
                r_pay <= {i_rx_byte, r_pay[sfd_pkg::PAY_W-1:8]};
                r_sum <= r_sum + i_rx_byte;
            end
            if (r_pos == sfd_pkg::POS_CHK) begin
                r_chk <= i_rx_byte;
            end
            if (r_pos == sfd_pkg::POS_TRL_A) begin
                r_trl_ok <= (i_rx_byte == sfd_pkg::TRL_A);
            end
        end
    end

    // Frame record handed to the queue with the last byte.
    always_comb begin
        o_frame.x_raw       = r_pay[31:0];
        o_frame.y_raw       = r_pay[63:32];
        o_frame.z_raw       = r_pay[95:64];
        o_frame.roll_raw    = r_pay[111:96];
        o_frame.action_code = r_pay[119:112];
        o_frame.ok          = r_trl_ok && (i_rx_byte == sfd_pkg::TRL_B) && (r_sum == r_chk);
    end

    // The parser position never leaves the frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= sfd_pkg::POS_TRL_B)
        else $error("parser position out of range");

    // A pushed frame always restarts the hunt.
    a_push_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_pos == sfd_pkg::POS_HUNT)
        else $error("parser did not restart after a frame");

endmodule

`default_nettype wire

FILE: rtl/core/sfd_queue.sv
`default_nettype none

module sfd_queue #(
    parameter int DEPTH = sfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sfd_pkg::t_frame i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output sfd_pkg::t_frame      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfd_pkg::t_frame  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // The parser holds its last byte while the queue is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    // The output stage pops only what is there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/core/sfd_back.sv
`default_nettype none

module sfd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire sfd_pkg::t_frame i_q_data,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [31:0]          o_x_raw,
    output logic [31:0]          o_y_raw,
    output logic [31:0]          o_z_raw,
    output logic [15:0]          o_roll_raw,
    output logic [7:0]           o_action_code
);

    logic r_valid;

    // Take the next frame when the output register is free or being emptied.
    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;

    // Output valid: good frames load, bad frames are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_q_data.ok) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output fields.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_data.ok) begin
            o_x_raw       <= i_q_data.x_raw;
            o_y_raw       <= i_q_data.y_raw;
            o_z_raw       <= i_q_data.z_raw;
            o_roll_raw    <= i_q_data.roll_raw;
            o_action_code <= i_q_data.action_code;
        end
    end

    // A dropped frame never shows up as a result.
    a_drop_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_q_data.ok && !r_valid) |=> !r_valid)
        else $error("bad frame produced a result");

endmodule

`default_nettype wire

FILE: rtl/core/sync_sum_frame_deframer_top.sv
`default_nettype none

// Frame deframer for a byte stream: it hunts for the header AA 55, collects a
// 20-byte frame, checks the 0D 0A trailer and the 8-bit sum of bytes 2..16
// against byte 17, and returns x, y, z, roll and action fields of each good
// frame, assembled little-endian; bad frames vanish without a result. One byte
// is accepted every cycle. The parser stalls only on the last byte of a frame,
// and only when the frame queue (QUEUE_DEPTH entries) is full, because the
// output register has not been emptied. With the queue empty and the output
// register free, a frame passes through the queue into the output register.
module sync_sum_frame_deframer_top #(
    parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_ready,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_x_raw,
    output logic [31:0]      o_y_raw,
    output logic [31:0]      o_z_raw,
    output logic [15:0]      o_roll_raw,
    output logic [7:0]       o_action_code
);

    sfd_pkg::t_frame w_push_data;
    sfd_pkg::t_frame w_pop_data;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_q_valid;

    // Byte parser.
    sfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_ready   (o_ready),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_frame   (w_push_data)
    );

    // Frame queue.
    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_data)
    );

    // Validation drop and output register.
    sfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_pop_data),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_x_raw       (o_x_raw),
        .o_y_raw       (o_y_raw),
        .o_z_raw       (o_z_raw),
        .o_roll_raw    (o_roll_raw),
        .o_action_code (o_action_code)
    );

endmodule

`default_nettype wire

FILE: sim/tb_sync_sum_frame_deframer_top.sv
`default_nettype none

module tb_sync_sum_frame_deframer_top;

    // Fields of one decoded frame, as the block returns them.
    typedef struct packed {
        logic [31:0] x_raw;
        logic [31:0] y_raw;
        logic [31:0] z_raw;
        logic [15:0] roll_raw;
        logic [7:0]  action_code;
    } t_frame_fields;

    // One byte waiting to be sent; drain_first holds it back until all frames are out.
    typedef struct {
        logic [7:0] data;
        bit         drain_first;
    } t_rx_item;

    typedef enum {FLAW_NONE, FLAW_SUM, FLAW_TRL_A, FLAW_TRL_B} t_frame_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_x_raw;
    logic [31:0] o_y_raw;
    logic [31:0] o_z_raw;
    logic [15:0] o_roll_raw;
    logic [7:0]  o_action_code;

    t_rx_item      rx_items[$];
    t_frame_fields decoded_frames[$];

    // Shadow of the parser state.
    logic [sfd_pkg::POS_W-1:0] shadow_pos = sfd_pkg::POS_HUNT;
    logic [7:0]                shadow_frame [sfd_pkg::FRAME_LEN];

    int  mismatches = 0;
    int  frames_seen = 0;
    int  frame_bytes = 0;
    bit  drain_pending = 1'b0;

    // Driver and monitor pacing state.
    int  tx_gap = 0;
    int  tx_burst = 0;
    bit  tx_calm = 1'b0;
    int  rx_gap = 0;
    int  rx_burst = 0;
    bit  rx_calm = 1'b0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;

    sync_sum_frame_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_rx_byte     (i_rx_byte),
        .o_ready       (o_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_x_raw       (o_x_raw),
        .o_y_raw       (o_y_raw),
        .o_z_raw       (o_z_raw),
        .o_roll_raw    (o_roll_raw),
        .o_action_code (o_action_code)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the shadow parser by one byte and queue a decoded frame when one completes.
    task automatic parse_byte(input logic [7:0] b);
        logic [7:0]    sum;
        t_frame_fields f;
        sum = 8'd0;
        if (shadow_pos == sfd_pkg::POS_HUNT) begin
            if (b == sfd_pkg::HDR_A) begin
                shadow_frame[0] = b;
                shadow_pos = sfd_pkg::POS_HDR;
            end
        end else if (shadow_pos == sfd_pkg::POS_HDR) begin
            if (b == sfd_pkg::HDR_B) begin
                shadow_frame[1] = b;
                shadow_pos = sfd_pkg::POS_DATA;
            end else if (b == sfd_pkg::HDR_A) begin
                shadow_frame[0] = b;
            end else begin
                shadow_pos = sfd_pkg::POS_HUNT;
            end
        end else begin
            shadow_frame[shadow_pos] = b;
            if (shadow_pos == sfd_pkg::POS_TRL_B) begin
                shadow_pos = sfd_pkg::POS_HUNT;
                for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) begin
                    sum = sum + shadow_frame[2 + k];
                end
                if (shadow_frame[0] == sfd_pkg::HDR_A &&
                    shadow_frame[1] == sfd_pkg::HDR_B &&
                    shadow_frame[sfd_pkg::POS_TRL_A] == sfd_pkg::TRL_A &&
                    shadow_frame[sfd_pkg::POS_TRL_B] == sfd_pkg::TRL_B &&
                    sum == shadow_frame[sfd_pkg::POS_CHK]) begin
                    f.x_raw = {shadow_frame[5], shadow_frame[4], shadow_frame[3],
                               shadow_frame[2]};
                    f.y_raw = {shadow_frame[9], shadow_frame[8], shadow_frame[7],
                               shadow_frame[6]};
                    f.z_raw = {shadow_frame[13], shadow_frame[12], shadow_frame[11],
                               shadow_frame[10]};
                    f.roll_raw = {shadow_frame[15], shadow_frame[14]};
                    f.action_code = shadow_frame[16];
                    decoded_frames.push_back(f);
                end
            end else begin
                shadow_pos = shadow_pos + 1'b1;
            end
        end
    endtask

    // Idle length for either side: mostly short, a few long, with calm stretches.
    function automatic int pick_gap(inout int burst_left, inout bit calm);
        int r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 200);
            calm = ($urandom_range(0, 3) == 0);
        end
        burst_left--;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random byte that often lands on the header and trailer codes or the extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0: return sfd_pkg::HDR_A;
            1: return sfd_pkg::HDR_B;
            2: return sfd_pkg::TRL_A;
            3: return sfd_pkg::TRL_B;
            4: return 8'h00;
            5: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        t_rx_item it;
        it.data = b;
        it.drain_first = drain_pending;
        drain_pending = 1'b0;
        rx_items.push_back(it);
    endtask

    // Queue one 20-byte frame, optionally spoiled in its checksum or trailer.
    task automatic push_frame(input logic [7:0] pay [sfd_pkg::SUM_SPAN],
                              input t_frame_flaw flaw);
        logic [7:0] sum;
        logic [7:0] tr_a;
        logic [7:0] tr_b;
        sum = 8'd0;
        tr_a = sfd_pkg::TRL_A;
        tr_b = sfd_pkg::TRL_B;
        for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) begin
            sum = sum + pay[k];
        end
        case (flaw)
            FLAW_SUM:   sum = sum + 8'($urandom_range(1, 255));
            FLAW_TRL_A: tr_a = tr_a ^ 8'($urandom_range(1, 255));
            FLAW_TRL_B: tr_b = tr_b ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
        push_byte(sfd_pkg::HDR_A);
        push_byte(sfd_pkg::HDR_B);
        for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) begin
            push_byte(pay[k]);
        end
        push_byte(sum);
        push_byte(tr_a);
        push_byte(tr_b);
        frame_bytes += sfd_pkg::FRAME_LEN;
    endtask

    // Driver: predicts each accepted byte and presents the next one after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                parse_byte(i_rx_byte);
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (rx_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (rx_items[0].drain_first && decoded_frames.size() != 0) begin
                    i_valid <= 1'b0;
                    tx_gap = 8;
                end else begin
                    i_rx_byte <= rx_items[0].data;
                    i_valid <= 1'b1;
                    void'(rx_items.pop_front());
                    tx_gap = pick_gap(tx_burst, tx_calm);
                end
            end
        end
    end

    // Monitor: checks each accepted frame against the oldest prediction and paces ready.
    always @(posedge i_clk) begin
        t_frame_fields got;
        t_frame_fields want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_x_raw, o_y_raw, o_z_raw, o_roll_raw, o_action_code};
                frames_seen++;
                if (decoded_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected frame: x %h y %h z %h roll %h action %h",
                                 got.x_raw, got.y_raw, got.z_raw, got.roll_raw,
                                 got.action_code);
                    end
                end else begin
                    want = decoded_frames.pop_front();
                    if (got.x_raw !== want.x_raw || got.y_raw !== want.y_raw ||
                        got.z_raw !== want.z_raw || got.roll_raw !== want.roll_raw ||
                        got.action_code !== want.action_code) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("frame %0d mismatch: expected x %h y %h z %h %s %h %h",
                                     frames_seen, want.x_raw, want.y_raw, want.z_raw,
                                     "roll/action", want.roll_raw, want.action_code);
                            $display("    actual x %h y %h z %h roll %h action %h",
                                     got.x_raw, got.y_raw, got.z_raw, got.roll_raw,
                                     got.action_code);
                        end
                    end
                end
            end
            // One long hold-off so the frame queue fills and the byte input stalls.
            if (!long_hold_done && frames_seen == 10) begin
                long_hold_left = 400;
                long_hold_done = 1'b1;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                rx_gap = pick_gap(rx_burst, rx_calm);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [7:0] pay [sfd_pkg::SUM_SPAN];
        int         r;
        int         n;
        int         next_drain;

        // Other byte after AA, then a repeated AA before the 55; payload all zero.
        push_byte(sfd_pkg::HDR_A);
        push_byte(8'h07);
        push_byte(sfd_pkg::HDR_A);
        push_byte(sfd_pkg::HDR_A);
        for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) pay[k] = 8'h00;
        push_frame(pay, FLAW_NONE);
        // All ones payload.
        for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) pay[k] = 8'hFF;
        push_frame(pay, FLAW_NONE);
        // Header bytes inside the payload are plain data.
        for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) begin
            pay[k] = k[0] ? sfd_pkg::HDR_B : sfd_pkg::HDR_A;
        end
        push_frame(pay, FLAW_NONE);
        // Distinct bytes show the little-endian byte order.
        for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) pay[k] = 8'(8'h11 * (k + 1));
        push_frame(pay, FLAW_SUM);
        push_frame(pay, FLAW_TRL_A);
        push_frame(pay, FLAW_TRL_B);
        push_frame(pay, FLAW_NONE);

        // Random part: mostly well-formed frames, some spoiled, some noise.
        drain_pending = 1'b1;
        next_drain = frame_bytes + 400;
        while (frame_bytes < 1600) begin
            if (frame_bytes >= next_drain) begin
                drain_pending = 1'b1;
                next_drain = frame_bytes + 400;
            end
            r = $urandom_range(0, 99);
            for (int k = 0; k < sfd_pkg::SUM_SPAN; k++) pay[k] = pick_byte();
            if (r < 68) begin
                push_frame(pay, FLAW_NONE);
            end else if (r < 76) begin
                push_frame(pay, FLAW_SUM);
            end else if (r < 80) begin
                push_frame(pay, FLAW_TRL_A);
            end else if (r < 84) begin
                push_frame(pay, FLAW_TRL_B);
            end else if (r < 93) begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) push_byte(pick_byte());
            end else if (r < 97) begin
                // Header followed by a short run of bytes that a later frame completes.
                push_byte(sfd_pkg::HDR_A);
                push_byte(sfd_pkg::HDR_B);
                n = $urandom_range(1, 17);
                for (int k = 0; k < n; k++) push_byte(pick_byte());
            end else begin
                push_byte(sfd_pkg::HDR_A);
                push_byte(8'($urandom_range(0, 1) ? 8'h00 : 8'h54));
            end
        end

        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_items.size() != 0 || i_valid) @(posedge i_clk);
        while (decoded_frames.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sync_sum_frame_deframer_top verification clean");
        end else begin
            $display("sync_sum_frame_deframer_top verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10000000;
        $display("sync_sum_frame_deframer_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_front.sv
rtl/core/sfd_queue.sv
rtl/core/sfd_back.sv
rtl/core/sync_sum_frame_deframer_top.sv
sim/tb_sync_sum_frame_deframer_top.sv
